FILE: rtl/core/pcr_avg_pkg.sv
`timescale 1ns / 1ps
package pcr_avg_pkg;
    localparam int unsigned WindowReset = 40;
    localparam int unsigned WideW = 73;
    localparam int unsigned SumW = 74;

    typedef enum logic [3:0] {
        S_IDLE, S_PCR_MUL, S_PCR_DIV, S_OFF_CALC, S_OFF_PREP, S_OFF_DIV, S_OFF_DONE,
        S_JIT_PREP, S_JIT_DIV, S_JIT_DONE, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic pcr_mul;
        logic conv_step;
        logic off_calc;
        logic mean_prep_off;
        logic mean_prep_jit;
        logic div_step;
        logic off_done;
        logic jit_done;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_status;
endpackage

FILE: rtl/core/pcr_clock_offset_averager.sv
`timescale 1ns / 1ps
// PCR clock offset averager. One request is handled at a time: the next
// request is taken only after the result of the last is loaded into the output
// register. The base times 300 is divided by 27 in six radix-256 reciprocal
// steps, then a shared bit-serial restoring divider runs 73 steps for each
// running mean (offset, then jitter); the other states load the request, form
// the offset, set up and commit each mean and load the output register. While
// a result waits under output stall the block stays in its output state and
// stalls the next request.
module pcr_clock_offset_averager
    import pcr_avg_pkg::*;
#(
    parameter logic [7:0] WINDOW_RESET = 8'(WindowReset)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [7:0]  i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic        [31:0] i_pcr_high_word,
    input  logic        [7:0]  i_pcr_fifth_byte,
    input  logic        [62:0] i_local_time_us,
    input  logic               i_discontinuity,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_smoothed_offset,
    output logic signed [63:0] o_sample_jitter,
    output logic signed [63:0] o_peak_jitter_out,
    output logic signed [63:0] o_mean_jitter_out
);
    t_cmd    cmd;
    t_status status;
    logic [7:0] r_window;
    logic r_ovalid;
    logic signed [63:0] smo, jit, pk, mjt;

    assign o_cfg_ready = 1'b1;

    // hold window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_window <= WINDOW_RESET;
        else if (i_cfg_valid) r_window <= i_cfg_data;
    end

    pcr_avg_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_out_busy(r_ovalid && i_stall),
        .i_status(status), .o_cmd(cmd)
    );

    pcr_avg_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status), .i_window(r_window),
        .i_pcr_high_word, .i_pcr_fifth_byte, .i_local_time_us, .i_discontinuity,
        .o_smoothed(smo), .o_jitter(jit), .o_peak(pk), .o_mean_jit(mjt)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.out_load) r_ovalid <= 1'b1;
        else if (!i_stall) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            o_smoothed_offset <= smo;
            o_sample_jitter   <= jit;
            o_peak_jitter_out <= pk;
            o_mean_jitter_out <= mjt;
        end
    end

    assign o_valid = r_ovalid;
endmodule

FILE: rtl/core/pcr_avg_ctrl.sv
`timescale 1ns / 1ps
module pcr_avg_ctrl
    import pcr_avg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_out_busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid) n_state = S_PCR_MUL;
            S_PCR_MUL:  n_state = S_PCR_DIV;
            S_PCR_DIV:  if (i_status.div_last) n_state = S_OFF_CALC;
            S_OFF_CALC: n_state = S_OFF_PREP;
            S_OFF_PREP: n_state = S_OFF_DIV;
            S_OFF_DIV:  if (i_status.div_last) n_state = S_OFF_DONE;
            S_OFF_DONE: n_state = S_JIT_PREP;
            S_JIT_PREP: n_state = S_JIT_DIV;
            S_JIT_DIV:  if (i_status.div_last) n_state = S_JIT_DONE;
            S_JIT_DONE: n_state = S_OUT;
            S_OUT:      if (!i_out_busy) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                o_cmd.load = i_valid;
            end
            S_PCR_MUL:  o_cmd.pcr_mul = 1'b1;
            S_PCR_DIV:  o_cmd.conv_step = 1'b1;
            S_OFF_CALC: o_cmd.off_calc = 1'b1;
            S_OFF_PREP: o_cmd.mean_prep_off = 1'b1;
            S_OFF_DIV:  o_cmd.div_step = 1'b1;
            S_OFF_DONE: o_cmd.off_done = 1'b1;
            S_JIT_PREP: o_cmd.mean_prep_jit = 1'b1;
            S_JIT_DIV:  o_cmd.div_step = 1'b1;
            S_JIT_DONE: o_cmd.jit_done = 1'b1;
            S_OUT:      o_cmd.out_load = !i_out_busy;
            default:    o_cmd = '0;
        endcase
    end
endmodule

FILE: rtl/core/pcr_avg_dp.sv
`timescale 1ns / 1ps
module pcr_avg_dp
    import pcr_avg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic        [7:0]  i_window,
    input  logic        [31:0] i_pcr_high_word,
    input  logic        [7:0]  i_pcr_fifth_byte,
    input  logic        [62:0] i_local_time_us,
    input  logic               i_discontinuity,
    output logic signed [63:0] o_smoothed,
    output logic signed [63:0] o_jitter,
    output logic signed [63:0] o_peak,
    output logic signed [63:0] o_mean_jit
);
    logic        [32:0] r_base;
    logic        [62:0] r_local;
    logic               r_disc;
    logic signed [63:0] r_smooth, r_peak, r_meanj, r_off, r_jit;
    logic        [7:0]  r_ocnt, r_jcnt;
    // shared restoring divider: magnitude dividend, divisor, remainder
    logic        [WideW-1:0] r_num;
    logic        [7:0]  r_rem;
    logic        [7:0]  r_div;
    logic        [6:0]  r_bit;
    logic               r_neg;

    logic [7:0]  win, ocnt_c, jcnt_c, weight, divisor;
    logic        full;
    logic signed [63:0] mean_in, samp_in;
    logic signed [SumW-1:0] sum;
    logic [SumW-1:0] mag;
    logic [8:0]  trial;
    logic [63:0] q_abs, q_res;
    logic [63:0] jit_c;
    logic [63:0] mj, mp;
    // base * 300 and its radix-256 division by 27
    logic [47:0] pcr_prod;
    logic [12:0] cv_cur;
    logic [25:0] cv_prod;
    logic [7:0]  cv_q;
    logic [12:0] cv_sub;

    assign win = (i_window == 8'd0) ? 8'd1 : i_window;
    assign ocnt_c = r_disc ? 8'd0 : r_ocnt;
    assign jcnt_c = r_disc ? 8'd0 : r_jcnt;

    // pick operands for the running mean
    always_comb begin
        if (i_cmd.mean_prep_off) begin
            full = ocnt_c >= win;
            weight = full ? win - 8'd1 : ocnt_c;
            mean_in = r_smooth;
            samp_in = r_off;
        end else begin
            full = jcnt_c >= win;
            weight = full ? win - 8'd1 : jcnt_c;
            mean_in = r_meanj;
            samp_in = r_jit;
        end
        divisor = weight + 8'd1;
        sum = SumW'(mean_in) * $signed({1'b0, weight}) + SumW'(samp_in);
        mag = sum[SumW-1] ? -sum : sum;
    end

    // one quotient byte per step: remainder below 27 keeps the digit below 256
    assign pcr_prod = {15'd0, r_base} * 48'd300;
    assign cv_cur   = {r_rem[4:0], r_num[47:40]};
    assign cv_prod  = {13'd0, cv_cur} * 26'd9710;
    assign cv_q     = cv_prod[25:18];
    assign cv_sub   = cv_cur - {5'd0, cv_q} * 13'd27;

    assign trial = {r_rem, r_num[WideW-1]};
    assign o_status.div_last = (r_bit == 7'd0);
    assign q_abs = r_num[63:0];
    assign q_res = r_neg ? -q_abs : q_abs;
    assign jit_c = r_off - q_res;
    assign mj = r_jit[63] ? -r_jit : r_jit;
    assign mp = (r_disc ? 64'd0 : r_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_peak   <= '0;
            r_meanj  <= '0;
            r_ocnt   <= '0;
            r_jcnt   <= '0;
        end else begin
            // commit mean, clear counts on restart
            if (i_cmd.off_done) begin
                r_smooth <= q_res;
                r_jit    <= jit_c;
                r_ocnt   <= (ocnt_c >= win) ? ocnt_c : ocnt_c + 8'd1;
            end
            if (i_cmd.jit_done) begin
                r_meanj <= q_res;
                r_jcnt  <= (jcnt_c >= win) ? jcnt_c : jcnt_c + 8'd1;
                if (mj >= (mp[63] ? -mp : mp)) r_peak <= r_jit;
                else r_peak <= mp;
            end
        end
    end

    // payload and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base  <= {i_pcr_high_word, i_pcr_fifth_byte[7]};
            r_local <= i_local_time_us;
            r_disc  <= i_discontinuity;
        end
        if (i_cmd.pcr_mul) begin
            r_num <= WideW'(pcr_prod);
            r_rem <= '0;
            r_neg <= 1'b0;
            r_bit <= 7'd5;
        end else if (i_cmd.conv_step) begin
            r_num <= WideW'({r_num[39:0], cv_q});
            r_rem <= {3'd0, cv_sub[4:0]};
            r_bit <= r_bit - 7'd1;
        end else if (i_cmd.mean_prep_off || i_cmd.mean_prep_jit) begin
            r_num <= mag[WideW-1:0];
            r_div <= divisor;
            r_rem <= '0;
            r_neg <= sum[SumW-1];
            r_bit <= 7'(WideW - 1);
        end else if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_div}) begin
                r_rem <= trial[7:0] - r_div;
                r_num <= {r_num[WideW-2:0], 1'b1};
            end else begin
                r_rem <= trial[7:0];
                r_num <= {r_num[WideW-2:0], 1'b0};
            end
            r_bit <= r_bit - 7'd1;
        end
        // form the clock offset from the converted base
        if (i_cmd.off_calc) begin
            r_off <= $signed({1'b0, r_local} - r_num[63:0]);
        end
    end

    assign o_smoothed = r_smooth;
    assign o_jitter   = r_jit;
    assign o_peak     = r_peak;
    assign o_mean_jit = r_meanj;
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench
    import pcr_avg_pkg::*;
();

    typedef struct {
        logic [31:0] high_word;
        logic [7:0]  fifth_byte;
        logic [62:0] local_time;
        logic        disc;
    } t_pcr_req;

    typedef struct {
        logic signed [63:0] smoothed;
        logic signed [63:0] jitter;
        logic signed [63:0] peak;
        logic signed [63:0] mean;
    } t_avg_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_pcr_high_word = '0;
    logic [7:0]  i_pcr_fifth_byte = '0;
    logic [62:0] i_local_time_us = '0;
    logic        i_discontinuity = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [63:0] o_smoothed_offset, o_sample_jitter;
    logic signed [63:0] o_peak_jitter_out, o_mean_jitter_out;

    pcr_clock_offset_averager dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pcr_high_word(i_pcr_high_word), .i_pcr_fifth_byte(i_pcr_fifth_byte),
        .i_local_time_us(i_local_time_us), .i_discontinuity(i_discontinuity),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_smoothed_offset(o_smoothed_offset), .o_sample_jitter(o_sample_jitter),
        .o_peak_jitter_out(o_peak_jitter_out), .o_mean_jitter_out(o_mean_jitter_out)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [7:0]         win_reg;
    logic signed [63:0] avg_offset;
    logic [7:0]         off_cnt;
    logic signed [63:0] peak_jit;
    logic signed [63:0] avg_jit;
    logic [7:0]         jit_cnt;

    t_pcr_req pending_reqs[$];
    t_avg_res expected_results[$];
    int  error_count = 0;
    int  sent_count = 0;
    int  recv_count = 0;
    int  disc_count = 0;
    bit  quiet_mode = 1'b0;
    bit  hold_rx = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;

    // exact (sample + mean * weight) / div, truncated toward zero
    function automatic logic signed [63:0] blend(logic signed [63:0] sample,
            logic signed [63:0] mean, int unsigned weight, int unsigned div);
        logic signed [80:0] acc;
        acc = 81'(sample) + 81'(mean) * 81'(signed'({1'b0, weight}));
        acc = acc / 81'(signed'({1'b0, div}));
        return acc[63:0];
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_avg_res predict_offsets(t_pcr_req r);
        logic [63:0] base, pcr_us;
        logic signed [63:0] off, jit;
        int unsigned w;
        t_avg_res res;
        base = {31'b0, r.high_word, r.fifth_byte[7]};
        pcr_us = base * 64'd300 / 64'd27;
        off = {1'b0, r.local_time} - pcr_us;
        w = (win_reg == 0) ? 1 : win_reg;
        if (r.disc) begin
            off_cnt = 0;
            jit_cnt = 0;
            peak_jit = 0;
        end
        if (off_cnt >= w) begin
            avg_offset = blend(off, avg_offset, w - 1, w);
        end else begin
            avg_offset = blend(off, avg_offset, off_cnt, off_cnt + 1);
            off_cnt++;
        end
        jit = off - avg_offset;
        if (mag(jit) >= mag(peak_jit)) peak_jit = jit;
        if (jit_cnt >= w) begin
            avg_jit = blend(jit, avg_jit, w - 1, w);
        end else begin
            avg_jit = blend(jit, avg_jit, jit_cnt, jit_cnt + 1);
            jit_cnt++;
        end
        res.smoothed = avg_offset;
        res.jitter = jit;
        res.peak = peak_jit;
        res.mean = avg_jit;
        return res;
    endfunction

    // feed requests, with random idle bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_offsets(pending_reqs.pop_front()));
                sent_count++;
                if (pending_reqs.size() > 0 && (quiet_mode || $urandom_range(9) != 0)) begin
                    i_pcr_high_word <= pending_reqs[0].high_word;
                    i_pcr_fifth_byte <= pending_reqs[0].fifth_byte;
                    i_local_time_us <= pending_reqs[0].local_time;
                    i_discontinuity <= pending_reqs[0].disc;
                end else begin
                    i_valid <= 1'b0;
                    tx_gap <= $urandom_range(10, 0);
                end
            end else if (!i_valid) begin
                if (tx_gap > 0 && !quiet_mode) begin
                    tx_gap <= tx_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    i_valid <= 1'b1;
                    i_pcr_high_word <= pending_reqs[0].high_word;
                    i_pcr_fifth_byte <= pending_reqs[0].fifth_byte;
                    i_local_time_us <= pending_reqs[0].local_time;
                    i_discontinuity <= pending_reqs[0].disc;
                end
            end
        end
    end

    // check results, with random stall bursts
    always @(posedge i_clk) begin
        t_avg_res e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                recv_count++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    error_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_smoothed_offset !== e.smoothed) begin
                        $error("smoothed_offset expected %0d actual %0d",
                               e.smoothed, o_smoothed_offset);
                        error_count++;
                    end
                    if (o_sample_jitter !== e.jitter) begin
                        $error("sample_jitter expected %0d actual %0d",
                               e.jitter, o_sample_jitter);
                        error_count++;
                    end
                    if (o_peak_jitter_out !== e.peak) begin
                        $error("peak_jitter_out expected %0d actual %0d",
                               e.peak, o_peak_jitter_out);
                        error_count++;
                    end
                    if (o_mean_jitter_out !== e.mean) begin
                        $error("mean_jitter_out expected %0d actual %0d",
                               e.mean, o_mean_jitter_out);
                        error_count++;
                    end
                end
            end
            if (hold_rx) begin
                i_stall <= 1'b1;
            end else if (quiet_mode) begin
                i_stall <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_stall <= (rx_gap > 1);
            end else if ($urandom_range(7) == 0) begin
                rx_gap <= $urandom_range(11, 1);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic add_req(logic [31:0] hw, logic [7:0] fb, logic [62:0] lt, logic d);
        t_pcr_req r;
        r.high_word = hw;
        r.fifth_byte = fb;
        r.local_time = lt;
        r.disc = d;
        if (d) disc_count++;
        pending_reqs.push_back(r);
    endtask

    // realistic stream: base advancing steadily, local time tracking it with noise and occasional outliers
    task automatic add_stream(int n);
        logic [32:0] base;
        logic [62:0] lt;
        logic [63:0] us;
        base = {$urandom, 1'($urandom)};
        for (int i = 0; i < n; i++) begin
            base = base + 33'($urandom_range(3600, 100));
            us = {31'b0, base} * 300 / 27;
            lt = 63'(us + 64'd1000000 + 64'($urandom_range(2000)) - 64'd1000);
            if ($urandom_range(15) == 0) lt = 63'({$urandom, $urandom});
            add_req(base[32:1], {base[0], 7'($urandom)}, lt, $urandom_range(40) == 0);
        end
    endtask

    task automatic write_window(logic [7:0] w);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_reg = w;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        win_reg = 8'(WindowReset);
        avg_offset = 0;
        off_cnt = 0;
        peak_jit = 0;
        avg_jit = 0;
        jit_cnt = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: field extremes, discontinuity, wraparound jitter
        add_req('0, '0, '0, 1'b0);
        add_req('1, 8'hFF, '1, 1'b0);
        add_req('1, 8'h7F, '0, 1'b0);
        add_req('0, 8'h80, '1, 1'b1);
        add_req(32'h8000_0000, 8'h00, 63'h4000_0000_0000_0000, 1'b0);
        add_req('1, 8'hFF, '0, 1'b0);
        add_req('0, '0, '1, 1'b0);
        add_req(32'h5555_5555, 8'hAA, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1);
        add_req(32'hAAAA_AAAA, 8'h55, 63'h5555_5555_5555_5555, 1'b0);
        add_req(32'h1234_5678, 8'h80, 63'd1000, 1'b0);
        add_req(32'h1234_5678, 8'h80, 63'd1000, 1'b0);
        drain();
        write_window(8'd1);
        add_stream(8);
        drain();
        write_window(8'd0);
        add_stream(6);
        drain();
        write_window(8'd255);
        add_stream(300);
        // hold the receiver off long so the block backs up
        fork
            begin
                hold_rx = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none
        drain();
        write_window(8'd3);
        add_stream(300);
        drain();
        write_window(8'd255);
        add_stream(350);
        drain();
        write_window(8'($urandom_range(254, 2)));
        add_stream(350);
        drain();
        // quiet tail: no idling on either side
        write_window(8'd2);
        quiet_mode = 1'b1;
        add_stream(425);
        drain();
        $display("Sent %0d PCR requests (%0d with discontinuity), checked %0d results",
                 sent_count, disc_count, recv_count);
        $display("Windows covered 0, 1, 2, 3, 255 and a random one, with a long output hold");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/pcr_avg_pkg.sv
rtl/core/pcr_avg_ctrl.sv
rtl/core/pcr_avg_dp.sv
rtl/core/pcr_clock_offset_averager.sv
tb/sv/testbench.sv
